FILE: rtl/core/aes_block_decrypt_assert.svh
// Assertion macros for the AES block decrypt core.
// Used by the top level; expects signals named clk and rst_n in scope.
`ifndef AES_BLOCK_DECRYPT_ASSERT_SVH
`define AES_BLOCK_DECRYPT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AESBD_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aesbd same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define AESBD_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aesbd next-cycle check failed");

`endif

FILE: rtl/core/aesbd_pkg.sv
// Shared constants and GF(2^8) helpers for the AES block decrypt core.
// No dependencies; imported by every module of the core.
package aesbd_pkg;

  localparam int NumCells = 15;

  typedef logic [1:0] cell_op_t;
  localparam cell_op_t OP_PASS   = 2'd0;
  localparam cell_op_t OP_WHITEN = 2'd1;
  localparam cell_op_t OP_ROUND  = 2'd2;
  localparam cell_op_t OP_FINAL  = 2'd3;

  localparam logic [2:0] REG_KEY_MODE = 3'd0;
  localparam logic [2:0] REG_KEY_0_7  = 3'd1;
  localparam logic [2:0] REG_KEY_8_15 = 3'd2;
  localparam logic [2:0] REG_KEY_16_23 = 3'd3;
  localparam logic [2:0] REG_KEY_24_31 = 3'd4;

  typedef struct packed {
    cell_op_t     op;
    logic [127:0] rkey;
  } cell_ctl_t;

  // Entry 0 sits in the top byte.
  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  localparam logic [2047:0] INV_SBOX_TBL = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX_TBL[{~x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    return INV_SBOX_TBL[{~x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

FILE: rtl/core/aesbd_cell.sv
// One cell of the decrypt chain: a single inverse round, a whitening step or a pass.
// Depends on aesbd_pkg for the inverse S-box and GF helpers.
module aesbd_cell
  import aesbd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  cell_ctl_t    ctl,
  input  logic         up_valid,
  input  logic [127:0] up_data,
  output logic         up_ready,
  output logic         dn_valid,
  output logic [127:0] dn_data,
  input  logic         dn_ready
);

  logic         valid_r;
  logic [127:0] data_r;
  logic [127:0] data_nxt;
  logic [127:0] shifted;
  logic [127:0] keyed;
  logic [127:0] mixed;

  always_comb begin
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    logic [7:0] av [4];
    // Byte n of the state sits at bits 127-8n downward; byte 4c+r is row r, column c.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shifted[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] = inv_sbox(up_data[127 - 8 * (4 * c + r) -: 8]);
      end
    end
    keyed = shifted ^ ctl.rkey;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        av[r] = keyed[127 - 8 * (4 * c + r) -: 8];
        m2[r] = xtime(av[r]);
        m4[r] = xtime(m2[r]);
        m8[r] = xtime(m4[r]);
      end
      // Coefficients 14, 11, 13, 9 rotated per row.
      a0 = (m8[0] ^ m4[0] ^ m2[0]) ^ (m8[1] ^ m2[1] ^ av[1]) ^ (m8[2] ^ m4[2] ^ av[2])
           ^ (m8[3] ^ av[3]);
      a1 = (m8[0] ^ av[0]) ^ (m8[1] ^ m4[1] ^ m2[1]) ^ (m8[2] ^ m2[2] ^ av[2])
           ^ (m8[3] ^ m4[3] ^ av[3]);
      a2 = (m8[0] ^ m4[0] ^ av[0]) ^ (m8[1] ^ av[1]) ^ (m8[2] ^ m4[2] ^ m2[2])
           ^ (m8[3] ^ m2[3] ^ av[3]);
      a3 = (m8[0] ^ m2[0] ^ av[0]) ^ (m8[1] ^ m4[1] ^ av[1]) ^ (m8[2] ^ av[2])
           ^ (m8[3] ^ m4[3] ^ m2[3]);
      mixed[127 - 32 * c -: 32] = {a0, a1, a2, a3};
    end
    unique case (ctl.op)
      OP_PASS:   data_nxt = up_data;
      OP_WHITEN: data_nxt = up_data ^ ctl.rkey;
      OP_ROUND:  data_nxt = mixed;
      OP_FINAL:  data_nxt = keyed;
      default:   data_nxt = up_data;
    endcase
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: rtl/core/aesbd_keyexp.sv
// Key schedule sequencer: expands the cipher key one word per cycle into round keys.
// Depends on aesbd_pkg for the S-box and xtime.
module aesbd_keyexp
  import aesbd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [1:0]   key_mode,
  input  logic [63:0]  key_0_7,
  input  logic [63:0]  key_8_15,
  input  logic [63:0]  key_16_23,
  input  logic [63:0]  key_24_31,
  output logic         busy,
  output logic [127:0] rkeys [NumCells]
);

  logic         busy_r;
  logic [5:0]   idx_r;
  logic [2:0]   pos_r;
  logic [7:0]   rc_r;
  logic [31:0]  win_r [8];
  logic [127:0] rk_r [NumCells];

  logic [3:0]   nk;
  logic [5:0]   total;
  logic [31:0]  kw [8];
  logic [31:0]  prev;
  logic [31:0]  old;
  logic [31:0]  word_nxt;
  logic         in_key;

  assign nk    = key_mode[1] ? 4'd8 : (key_mode[0] ? 4'd6 : 4'd4);
  assign total = {nk + 4'd7, 2'b00};
  assign kw[0] = key_0_7[63:32];
  assign kw[1] = key_0_7[31:0];
  assign kw[2] = key_8_15[63:32];
  assign kw[3] = key_8_15[31:0];
  assign kw[4] = key_16_23[63:32];
  assign kw[5] = key_16_23[31:0];
  assign kw[6] = key_24_31[63:32];
  assign kw[7] = key_24_31[31:0];

  assign in_key = idx_r < {2'b00, nk};
  assign prev   = win_r[7];

  always_comb begin
    unique case (nk)
      4'd8:    old = win_r[0];
      4'd6:    old = win_r[2];
      default: old = win_r[4];
    endcase
    priority if (in_key) begin
      word_nxt = kw[idx_r[2:0]];
    end else if (pos_r == 3'd0) begin
      word_nxt = old ^ sub_word({prev[23:0], prev[31:24]}) ^ {rc_r, 24'h000000};
    end else if (nk == 4'd8 && pos_r == 3'd4) begin
      word_nxt = old ^ sub_word(prev);
    end else begin
      word_nxt = old ^ prev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      pos_r  <= '0;
      rc_r   <= 8'h01;
    end else if (busy_r) begin
      idx_r  <= idx_r + 6'd1;
      pos_r  <= (pos_r == 3'(nk - 4'd1)) ? 3'd0 : pos_r + 3'd1;
      if (!in_key && pos_r == 3'd0) begin
        rc_r <= xtime(rc_r);
      end
      if (idx_r == total - 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && rst_n && !start) begin
      for (int i = 0; i < 7; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[7] <= word_nxt;
      rk_r[idx_r[5:2]][127 - 32 * idx_r[1:0] -: 32] <= word_nxt;
    end
  end

  assign busy  = busy_r;
  assign rkeys = rk_r;

endmodule

FILE: rtl/core/aes_block_decrypt.sv
// Channel  Dir  Payload (low bits first)                     Handshake
// in_      in   tdata: cipher_high[63:0], cipher_low[127:64]  in_tvalid / in_tready
// out_     out  tdata: plain_high[63:0], plain_low[127:64]    out_tvalid / out_tready
// cfg_     in   cfg_index[2:0], cfg_data[63:0]               cfg_valid / cfg_ready
//
// A chain of 15 registered cells (whitening, then 14 round slots) takes one word per
// cycle when not stalled; shorter keys pass through the leading round slots.
// Reset and every key register write start the key schedule, which writes one
// round-key word per cycle, 44, 52 or 60 words in all; in_tready is low meanwhile.
// A stalled output holds only the cells behind it that are full; bubbles close up.
// Depends on aesbd_pkg, aesbd_cell, aesbd_keyexp and aes_block_decrypt_assert.svh.
`include "aes_block_decrypt_assert.svh"
module aes_block_decrypt
  import aesbd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // cipher_high [63:0], cipher_low [127:64]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // plain_high [63:0], plain_low [127:64]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [1:0]   key_mode_r;
  logic [63:0]  key_0_7_r;
  logic [63:0]  key_8_15_r;
  logic [63:0]  key_16_23_r;
  logic [63:0]  key_24_31_r;
  logic         cfg_wr;
  logic         ks_busy;
  logic [127:0] rkeys [NumCells];
  logic [3:0]   nr;

  logic         c_valid [NumCells + 1];
  logic [127:0] c_data  [NumCells + 1];
  logic         c_ready [NumCells + 1];
  cell_ctl_t    ctl     [NumCells];

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_index <= REG_KEY_24_31;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mode_r  <= '0;
      key_0_7_r   <= '0;
      key_8_15_r  <= '0;
      key_16_23_r <= '0;
      key_24_31_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY_MODE:  key_mode_r  <= cfg_data[1:0];
        REG_KEY_0_7:   key_0_7_r   <= cfg_data;
        REG_KEY_8_15:  key_8_15_r  <= cfg_data;
        REG_KEY_16_23: key_16_23_r <= cfg_data;
        REG_KEY_24_31: key_24_31_r <= cfg_data;
        default: ;
      endcase
    end
  end

  aesbd_keyexp u_keyexp (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cfg_wr),
    .key_mode  (key_mode_r),
    .key_0_7   (key_0_7_r),
    .key_8_15  (key_8_15_r),
    .key_16_23 (key_16_23_r),
    .key_24_31 (key_24_31_r),
    .busy      (ks_busy),
    .rkeys     (rkeys)
  );

  assign nr = key_mode_r[1] ? 4'd14 : (key_mode_r[0] ? 4'd12 : 4'd10);

  // Cell 0 adds the last round key; cell p then undoes round 14-p, or passes.
  always_comb begin
    ctl[0].op   = OP_WHITEN;
    ctl[0].rkey = rkeys[nr];
    for (int p = 1; p < NumCells; p++) begin
      ctl[p].rkey = rkeys[NumCells - 1 - p];
      if (4'(p) <= 4'd14 - nr) begin
        ctl[p].op = OP_PASS;
      end else if (p == NumCells - 1) begin
        ctl[p].op = OP_FINAL;
      end else begin
        ctl[p].op = OP_ROUND;
      end
    end
  end

  assign c_valid[0] = in_tvalid && !ks_busy;
  assign c_data[0]  = {in_tdata[63:0], in_tdata[127:64]};
  assign in_tready  = c_ready[0] && !ks_busy;
  assign c_ready[NumCells] = out_tready;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    aesbd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl[g]),
      .up_valid (c_valid[g]),
      .up_data  (c_data[g]),
      .up_ready (c_ready[g]),
      .dn_valid (c_valid[g + 1]),
      .dn_data  (c_data[g + 1]),
      .dn_ready (c_ready[g + 1])
    );
  end

  assign out_tvalid = c_valid[NumCells];
  assign out_tdata  = {c_data[NumCells][63:0], c_data[NumCells][127:64]};

  `AESBD_IMPLIES(a_no_accept_while_expanding, ks_busy, !in_tready)
  `AESBD_NEXT(a_cfg_restarts_schedule, cfg_wr, ks_busy)
  `AESBD_NEXT(a_accept_fills_first_cell, in_tvalid && in_tready, c_valid[1])
  `AESBD_IMPLIES(a_full_output_blocks_chain, c_valid[NumCells] && !out_tready,
                 !c_ready[NumCells - 1])

endmodule

FILE: test/aes_block_decrypt_tb.sv
// Self-checking testbench for aes_block_decrypt: AES inverse cipher with 128, 192 and 256-bit keys.
// Holds its own AES decryption model and compares every output word with it.
// Depends on aesbd_pkg and the core RTL only.
`timescale 1ns / 100ps
module aes_block_decrypt_tb;
  import aesbd_pkg::*;

  localparam int CycleLimit = 400000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [63:0]  cfg_data;

  aes_block_decrypt dut (.*);

  // Key registers as the block should hold them, and the derived schedule.
  logic [1:0]  key_mode_q;
  logic [63:0] key_regs[4];
  logic [31:0] round_words[60];
  int          num_rounds;
  logic [7:0]  fwd_sbox[256];
  logic [7:0]  rev_sbox[256];

  logic [127:0] cipher_q[$];
  logic [127:0] plain_q[$];
  int  fail_cnt;
  int  cycle_cnt;
  int  words_in;
  int  words_out;
  int  cfg_writes;
  int  burst_left;
  int  gap_left;
  bit  tx_steady;
  bit  tx_pause;
  int  rx_style;
  bit  rx_long_req;
  int  rx_hold_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] gf_recip(input logic [7:0] x);
    logic [7:0] r;
    r = 8'h01;
    // x^254 by repeated multiplication; zero stays zero.
    for (int i = 0; i < 254; i++) r = gf_mult(r, x);
    return (x == 8'h00) ? 8'h00 : r;
  endfunction

  function automatic logic [7:0] rol8(input logic [7:0] b, input int n);
    return (b << n) | (b >> (8 - n));
  endfunction

  task automatic build_sboxes();
    logic [7:0] b;
    for (int x = 0; x < 256; x++) begin
      b = gf_recip(x[7:0]);
      fwd_sbox[x] = b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
      b = rol8(x[7:0], 1) ^ rol8(x[7:0], 3) ^ rol8(x[7:0], 6) ^ 8'h05;
      rev_sbox[x] = gf_recip(b);
    end
  endtask

  function automatic logic [31:0] subst_word(input logic [31:0] w);
    return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
  endfunction

  task automatic expand_round_words();
    int nk;
    logic [7:0] rcon;
    logic [31:0] t;
    nk = key_mode_q[1] ? 8 : (key_mode_q[0] ? 6 : 4);
    num_rounds = nk + 6;
    rcon = 8'h01;
    for (int i = 0; i < 8; i++)
      round_words[i] = key_regs[i / 2][((i % 2 == 0) ? 63 : 31) -: 32];
    for (int i = nk; i < 4 * (num_rounds + 1); i++) begin
      t = round_words[i - 1];
      if (i % nk == 0) begin
        t = subst_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
        rcon = gf_mult(rcon, 8'h02);
      end else if (nk > 6 && i % nk == 4) begin
        t = subst_word(t);
      end
      round_words[i] = round_words[i - nk] ^ t;
    end
  endtask

  // Decrypts one block; returns {plain_low, plain_high} as packed on out_tdata.
  function automatic logic [127:0] decrypt_block(input logic [127:0] word);
    logic [7:0]  st[16];
    logic [7:0]  tmp[16];
    logic [7:0]  a0, a1, a2, a3;
    logic [63:0] hi, lo;
    for (int n = 0; n < 8; n++) begin
      st[n]     = word[63 - 8 * n -: 8];
      st[n + 8] = word[127 - 8 * n -: 8];
    end
    for (int rnd = num_rounds; rnd >= 0; rnd--) begin
      if (rnd != num_rounds) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) tmp[4 * ((c + r) % 4) + r] = rev_sbox[st[4 * c + r]];
        st = tmp;
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) st[4 * c + r] ^= round_words[4 * rnd + c][31 - 8 * r -: 8];
      if (rnd != num_rounds && rnd != 0) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4 * c]; a1 = st[4 * c + 1]; a2 = st[4 * c + 2]; a3 = st[4 * c + 3];
          st[4 * c]     = gf_mult(a0, 8'd14) ^ gf_mult(a1, 8'd11) ^ gf_mult(a2, 8'd13)
                          ^ gf_mult(a3, 8'd9);
          st[4 * c + 1] = gf_mult(a0, 8'd9) ^ gf_mult(a1, 8'd14) ^ gf_mult(a2, 8'd11)
                          ^ gf_mult(a3, 8'd13);
          st[4 * c + 2] = gf_mult(a0, 8'd13) ^ gf_mult(a1, 8'd9) ^ gf_mult(a2, 8'd14)
                          ^ gf_mult(a3, 8'd11);
          st[4 * c + 3] = gf_mult(a0, 8'd11) ^ gf_mult(a1, 8'd13) ^ gf_mult(a2, 8'd9)
                          ^ gf_mult(a3, 8'd14);
        end
      end
    end
    for (int n = 0; n < 8; n++) begin
      hi = {hi[55:0], st[n]};
      lo = {lo[55:0], st[n + 8]};
    end
    return {lo, hi};
  endfunction

  // Sender: bursts and gaps, unless running steady or paused.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        plain_q.push_back(decrypt_block(in_tdata));
        words_in <= words_in + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (!tx_steady && gap_left > 0) begin
          gap_left  <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (cipher_q.size() > 0 && !tx_pause) begin
          in_tvalid <= 1'b1;
          in_tdata  <= cipher_q.pop_front();
          if (!tx_steady) begin
            if (burst_left <= 1) begin
              burst_left <= $urandom_range(1, 12);
              gap_left   <= $urandom_range(0, 6);
            end else begin
              burst_left <= burst_left - 1;
            end
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern chosen per phase, plus an occasional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      rx_hold_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        words_out <= words_out + 1;
        if (plain_q.size() == 0) begin
          $error("output word with no expected value: %h", out_tdata);
          fail_cnt++;
        end else begin
          if (out_tdata[63:0] !== plain_q[0][63:0]) begin
            $error("plain_high: expected %h, actual %h", plain_q[0][63:0], out_tdata[63:0]);
            fail_cnt++;
          end
          if (out_tdata[127:64] !== plain_q[0][127:64]) begin
            $error("plain_low: expected %h, actual %h", plain_q[0][127:64], out_tdata[127:64]);
            fail_cnt++;
          end
          void'(plain_q.pop_front());
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left <= rx_hold_left - 1;
        out_tready   <= 1'b0;
      end else if (rx_long_req) begin
        rx_long_req  <= 1'b0;
        rx_hold_left <= 300;
        out_tready   <= 1'b0;
      end else begin
        case (rx_style)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 9) < 7);
          default: out_tready <= (cycle_cnt % 7) < 3;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_idle();
    while (cipher_q.size() > 0 || in_tvalid || plain_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_KEY_MODE:  key_mode_q  = val[1:0];
      REG_KEY_0_7:   key_regs[0] = val;
      REG_KEY_8_15:  key_regs[1] = val;
      REG_KEY_16_23: key_regs[2] = val;
      REG_KEY_24_31: key_regs[3] = val;
      default: ;
    endcase
    expand_round_words();
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] edge64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'h5555_5555_5555_5555;
      3: return 64'haaaa_aaaa_aaaa_aaaa;
      4: return 64'h1 << $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++)
      cipher_q.push_back(($urandom_range(0, 7) == 0) ? {edge64(), edge64()}
                                                     : {rand64(), rand64()});
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    fail_cnt    = 0;
    cycle_cnt   = 0;
    words_in    = 0;
    words_out   = 0;
    cfg_writes  = 0;
    tx_steady   = 1'b0;
    tx_pause    = 1'b0;
    rx_style    = 0;
    rx_long_req = 1'b0;
    key_mode_q  = '0;
    for (int i = 0; i < 4; i++) key_regs[i] = '0;
    build_sboxes();
    expand_round_words();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset key (all zeros, 128-bit) with directed blocks.
    cipher_q.push_back('0);
    cipher_q.push_back('1);
    cipher_q.push_back({64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555});
    cipher_q.push_back(128'h1);
    cipher_q.push_back(128'h1 << 127);
    cipher_q.push_back(128'h1 << 63);

    // Standard test key with a fixed ciphertext for the 128-bit case, then the other sizes.
    write_reg(REG_KEY_0_7, 64'h0001_0203_0405_0607);
    write_reg(REG_KEY_8_15, 64'h0809_0a0b_0c0d_0e0f);
    write_reg(REG_KEY_16_23, 64'h1011_1213_1415_1617);
    write_reg(REG_KEY_24_31, 64'h1819_1a1b_1c1d_1e1f);
    cipher_q.push_back({64'hc5a5_5a70_b4c5_c830, 64'hd8cd_b768_0430_d869});
    cipher_q.push_back('1);
    write_reg(REG_KEY_MODE, 64'd1);
    cipher_q.push_back({64'h9171_0d7c_ee86_a0dd, 64'hdda0_7e6c_4a2c_a46e});
    cipher_q.push_back('0);
    write_reg(REG_KEY_MODE, 64'd2);
    cipher_q.push_back({64'hbe49_4b8b_5eea_2f8e, 64'h8960_4952_dbfc_ea89});
    cipher_q.push_back('0);
    // Mode 3 must behave as the 256-bit mode.
    write_reg(REG_KEY_MODE, 64'd3);
    cipher_q.push_back({64'hbe49_4b8b_5eea_2f8e, 64'h8960_4952_dbfc_ea89});
    // Writes above the last register index change nothing.
    write_reg(3'd5, '1);
    write_reg(3'd6, '1);
    write_reg(3'd7, 64'h5555_5555_5555_5555);
    cipher_q.push_back({64'hbe49_4b8b_5eea_2f8e, 64'h8960_4952_dbfc_ea89});

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_KEY_MODE, 64'((ph < 4) ? ph : $urandom_range(0, 3)));
      for (int k = 1; k <= 4; k++)
        write_reg(k[2:0], (ph == 1) ? '1 : (ph == 2) ? '0 : edge64());
      rx_style  = ph % 3;
      tx_steady = (ph % 4 == 3);
      if (ph == 2) begin
        // Receiver holds off while the sender keeps offering, filling the pipe.
        tx_steady = 1'b1;
        queue_random(120);
        rx_long_req = 1'b1;
        wait_idle();
        tx_steady = 1'b0;
      end
      queue_random(80);
      while (cipher_q.size() > 40) @(posedge clk);
      // Sender holds its remaining words until everything in flight has drained.
      tx_pause = 1'b1;
      while (in_tvalid || plain_q.size() > 0) @(posedge clk);
      tx_pause = 1'b0;
      queue_random(70);
    end
    wait_idle();
    repeat (40) @(posedge clk);
    $display("Decrypted %0d blocks (%0d checked) over %0d register writes,", words_in,
             words_out, cfg_writes);
    $display("covering all key modes, unused and out-of-range registers, and stalls.");
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/aesbd_pkg.sv
rtl/core/aesbd_cell.sv
rtl/core/aesbd_keyexp.sv
rtl/core/aes_block_decrypt.sv
test/aes_block_decrypt_tb.sv
